// ----- design/mbar_pkg.sv -----
`default_nettype none

package mbar_pkg;

    localparam int MAX_LINE_CHARS_DEFAULT = 23;
    localparam int MIN_REPLY_CHARS_DEFAULT = 15;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h01;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_TWO = 8'h32;
    localparam logic [7:0] CHAR_FOUR = 8'h34;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [0:0] {
        OP_CHAR    = 1'b0,
        OP_TIMEOUT = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_DEVICE_ADDRESS = 1'b0
    } reg_index_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TOO_SHORT = 3'd1,
        STATUS_BAD_HEADER = 3'd2,
        STATUS_BAD_HEX   = 3'd3,
        STATUS_BAD_LRC   = 3'd4
    } status_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_char;
    } in_item_t;

    typedef struct packed {
        logic [15:0] reg_value;
        logic [2:0]  status;
    } out_item_t;

    function automatic logic [7:0] upper_hex(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h41 + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    // Bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        else
        begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/mbar_cfg.sv -----
`default_nettype none

module mbar_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mbar_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [mbar_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [mbar_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output logic      [7:0]                          device_address
);

    logic [7:0] device_address_reg;
    logic       sel_device_address;

    assign sel_device_address =
        (paddr[mbar_pkg::CFG_ADDR_W-1] == mbar_pkg::REG_DEVICE_ADDRESS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= mbar_pkg::DEVICE_ADDRESS_RESET;
        end
        else if (psel && penable && pwrite && sel_device_address)
        begin
            device_address_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_device_address)
        begin
            prdata = {{(mbar_pkg::CFG_DATA_W-8){1'b0}}, device_address_reg};
        end
    end

    assign pready = 1'b1;
    assign device_address = device_address_reg;

endmodule

`default_nettype wire

// ----- design/mbar_line.sv -----
`default_nettype none

module mbar_line #(
    parameter int MAX_LINE_CHARS  = mbar_pkg::MAX_LINE_CHARS_DEFAULT,
    parameter int MIN_REPLY_CHARS = mbar_pkg::MIN_REPLY_CHARS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire mbar_pkg::in_item_t  item,
    input  wire logic [7:0]          device_address,
    output logic                     result_valid,
    output mbar_pkg::out_item_t      result
);

    localparam int POS_W = $clog2(MAX_LINE_CHARS + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       lrc_reg, lrc_next;
    logic [3:0]       hold_reg, hold_next;
    logic [15:0]      value_reg, value_next;
    logic [7:0]       rx_lrc_reg, rx_lrc_next;
    logic             header_good_reg, header_good_next;
    logic             hex_good_reg, hex_good_next;

    logic [POS_W-1:0] t_pos;
    logic [7:0]       t_lrc;
    logic [3:0]       t_hold;
    logic [15:0]      t_value;
    logic [7:0]       t_rx_lrc;
    logic             t_header_good;
    logic             t_hex_good;

    logic [POS_W-1:0] s_pos;
    logic [7:0]       s_lrc;
    logic [15:0]      s_value;
    logic [7:0]       s_rx_lrc;
    logic             s_header_good;
    logic             s_hex_good;

    logic [4:0]       hv;
    logic [3:0]       d;
    logic             is_hex;
    logic [7:0]       want;
    logic [7:0]       pair;
    logic [7:0]       expect_lrc;
    logic             is_timeout;
    logic             done;
    mbar_pkg::status_t status;

    assign is_timeout = (item.operation == mbar_pkg::OP_TIMEOUT);
    assign hv = mbar_pkg::hex_value(item.rx_char);
    assign is_hex = !hv[4];
    assign d = is_hex ? hv[3:0] : 4'd0;
    assign pair = {hold_reg, d};

    always_comb
    begin
        case (pos_reg)
            POS_W'(0): want = mbar_pkg::CHAR_COLON;
            POS_W'(1): want = mbar_pkg::upper_hex(device_address[7:4]);
            POS_W'(2): want = mbar_pkg::upper_hex(device_address[3:0]);
            POS_W'(3): want = mbar_pkg::CHAR_ZERO;
            POS_W'(4): want = mbar_pkg::CHAR_FOUR;
            POS_W'(5): want = mbar_pkg::CHAR_ZERO;
            default:   want = mbar_pkg::CHAR_TWO;
        endcase
    end

    always_comb
    begin
        t_pos = pos_reg + POS_W'(1);
        t_lrc = lrc_reg;
        t_hold = hold_reg;
        t_value = value_reg;
        t_rx_lrc = rx_lrc_reg;
        t_header_good = header_good_reg;
        t_hex_good = hex_good_reg;

        if (pos_reg <= POS_W'(6) && item.rx_char != want)
        begin
            t_header_good = 1'b0;
        end
        if (pos_reg >= POS_W'(1) && pos_reg <= POS_W'(12))
        begin
            if (!is_hex)
            begin
                t_hex_good = 1'b0;
            end
            if (pos_reg[0])
            begin
                t_hold = d;
            end
            else if (pos_reg <= POS_W'(10))
            begin
                t_lrc = lrc_reg + pair;
            end
            else
            begin
                t_rx_lrc = pair;
            end
            if (pos_reg >= POS_W'(7) && pos_reg <= POS_W'(10))
            begin
                t_value = {value_reg[11:0], d};
            end
        end
    end

    always_comb
    begin
        if (is_timeout)
        begin
            s_pos = pos_reg;
            s_lrc = lrc_reg;
            s_value = value_reg;
            s_rx_lrc = rx_lrc_reg;
            s_header_good = header_good_reg;
            s_hex_good = hex_good_reg;
        end
        else
        begin
            s_pos = t_pos;
            s_lrc = t_lrc;
            s_value = t_value;
            s_rx_lrc = t_rx_lrc;
            s_header_good = t_header_good;
            s_hex_good = t_hex_good;
        end
    end

    assign done = is_timeout || (item.rx_char == mbar_pkg::CHAR_NEWLINE)
                  || (t_pos >= POS_W'(MAX_LINE_CHARS));
    assign expect_lrc = 8'd0 - s_lrc;

    always_comb
    begin
        if (s_pos < POS_W'(MIN_REPLY_CHARS))
        begin
            status = mbar_pkg::STATUS_TOO_SHORT;
        end
        else if (!s_header_good)
        begin
            status = mbar_pkg::STATUS_BAD_HEADER;
        end
        else if (!s_hex_good)
        begin
            status = mbar_pkg::STATUS_BAD_HEX;
        end
        else if (expect_lrc != s_rx_lrc)
        begin
            status = mbar_pkg::STATUS_BAD_LRC;
        end
        else
        begin
            status = mbar_pkg::STATUS_OK;
        end
    end

    assign result_valid = step && done;
    assign result.status = status;
    assign result.reg_value = (status == mbar_pkg::STATUS_OK) ? s_value : 16'd0;

    always_comb
    begin
        if (done)
        begin
            pos_next = '0;
            lrc_next = '0;
            hold_next = '0;
            value_next = '0;
            rx_lrc_next = '0;
            header_good_next = 1'b1;
            hex_good_next = 1'b1;
        end
        else
        begin
            pos_next = t_pos;
            lrc_next = t_lrc;
            hold_next = t_hold;
            value_next = t_value;
            rx_lrc_next = t_rx_lrc;
            header_good_next = t_header_good;
            hex_good_next = t_hex_good;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            lrc_reg <= '0;
            hold_reg <= '0;
            value_reg <= '0;
            rx_lrc_reg <= '0;
            header_good_reg <= 1'b1;
            hex_good_reg <= 1'b1;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            lrc_reg <= lrc_next;
            hold_reg <= hold_next;
            value_reg <= value_next;
            rx_lrc_reg <= rx_lrc_next;
            header_good_reg <= header_good_next;
            hex_good_reg <= hex_good_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/modbus_ascii_read_reply_checker.sv -----
// Checks one Modbus ASCII reply to a single-register read, one character per beat.
// The input channel (in_valid, in_stall, in_data) carries either a received
// character or a timeout. A line ends on a newline, on a timeout beat, or
// when MAX_LINE_CHARS characters have been taken; each line end gives one
// beat on the output channel (out_valid, out_stall, out_data) with the
// decoded register value and a status code. Other beats give no output.
// The expected device address is written through the APB-style port at
// any byte address with paddr[2] low (0 to 3); it resets to 1.
// An accepted beat is held in the input register, and its result is then
// registered in the output register. One beat is accepted every cycle
// while in_stall is low.
// While out_stall holds a waiting result, the input register keeps any beat it
// holds, and in_stall rises while it holds one; no beat is lost. Reset empties both
// registers and clears the line state to an empty line.
`default_nettype none

module modbus_ascii_read_reply_checker #(
    parameter int MAX_LINE_CHARS  = mbar_pkg::MAX_LINE_CHARS_DEFAULT,
    parameter int MIN_REPLY_CHARS = mbar_pkg::MIN_REPLY_CHARS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire mbar_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output mbar_pkg::out_item_t                      out_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mbar_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [mbar_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [mbar_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    logic                item_valid_reg;
    mbar_pkg::in_item_t  item_reg;
    logic                out_valid_reg;
    mbar_pkg::out_item_t out_data_reg;

    logic                advance;
    logic                take;
    logic                result_valid;
    mbar_pkg::out_item_t result;
    logic [7:0]          device_address;

    mbar_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .device_address (device_address)
    );

    mbar_line #(
        .MAX_LINE_CHARS  (MAX_LINE_CHARS),
        .MIN_REPLY_CHARS (MIN_REPLY_CHARS)
    ) u_line (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .item           (item_reg),
        .device_address (device_address),
        .result_valid   (result_valid),
        .result         (result)
    );

    assign advance = item_valid_reg && !(out_valid_reg && out_stall);
    assign take = in_valid && !in_stall;
    assign in_stall = item_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance && result_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_data;
        end
        if (advance && result_valid)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

`default_nettype wire
